// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("%m: check failed");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// File: sv/bce_pkg.sv
// ----------------------------------------------------------------------------
// Branch confidence estimator package
// Sizes, codes, shared types and a helper function.
// ----------------------------------------------------------------------------
package bce_pkg;

	// Table and field sizes
	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int ENTRY_W       = 16;
	localparam int CNT_W         = $clog2(ENTRY_W + 1);
	localparam int NIB_W         = 4;
	localparam int NIBS          = ENTRY_W / NIB_W;
	localparam int NIB_CNT_W     = $clog2(NIB_W + 1);
	localparam int VAL_W         = ENTRY_W + 2;
	localparam int EBITS_W       = 5;
	localparam int MODE_W        = 2;
	localparam int NUM_THR       = 3;
	localparam int TIDX_W        = $clog2(NUM_THR);
	localparam int THR_W         = 17;
	localparam int TCNT_W        = 2;
	localparam int HIST_W        = 10;
	localparam int ADDR_W        = 32;
	localparam int ADDR_SHIFT    = 3;
	localparam int FREE_W        = 4;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 17;

	// Operation codes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// Entry modes
	localparam logic [MODE_W-1:0] MODE_ONES      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SAT       = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESET     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RESET_ALT = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_BITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_USE_HIST   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THR_SEL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THR_COUNT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_THR_ZERO   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_THR_ONE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_THR_TWO    = 3'd7;

	// Configuration reset values
	localparam logic [MODE_W-1:0]  RST_ENTRY_MODE = MODE_SAT;
	localparam logic [EBITS_W-1:0] RST_ENTRY_BITS = 5'd4;
	localparam logic [TCNT_W-1:0]  RST_THR_COUNT  = 2'd1;

	// Configuration as seen by the front and back
	typedef struct packed {
		logic [MODE_W-1:0]                entry_mode;
		logic [EBITS_W-1:0]               entry_bits;
		logic                             use_hist;
		logic                             thr_sel;
		logic [TCNT_W-1:0]                thr_count;
		logic [NUM_THR-1:0][THR_W-1:0]    thr;
	} bce_cfg_t;

	// Classified item travelling from front to back
	typedef struct packed {
		logic             op;
		logic [IDX_W-1:0] idx;
		logic             correct;
		logic             force_high;
		logic [TIDX_W-1:0] tidx;
	} bce_item_t;

	// Back status toward front and top
	typedef struct packed {
		logic clearing;
		logic executing;
	} bce_bstat_t;

	// Back sequencer states
	typedef enum logic [1:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_EXEC
	} bce_bstate_t;

	// Count ones of an entry, nibble counts first, then their sum
	function automatic logic [CNT_W-1:0] popcount(input logic [ENTRY_W-1:0] v);
		logic [NIB_CNT_W-1:0] part;
		logic [CNT_W-1:0]     sum;
		sum = '0;
		for (int g = 0; g < NIBS; g++) begin
			part = '0;
			for (int b = 0; b < NIB_W; b++) begin
				part = part + NIB_CNT_W'(v[g*NIB_W + b]);
			end
			sum = sum + CNT_W'(part);
		end
		return sum;
	endfunction

endpackage

// File: sv/bce_front.sv
// ----------------------------------------------------------------------------
// Branch confidence estimator front
// Accepts items, forms the table index from address and global history,
// picks the threshold and keeps the global taken history.
// ----------------------------------------------------------------------------
module bce_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bce_pkg::bce_cfg_t           cfg,
	input  bce_pkg::bce_bstat_t         bstat,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic [bce_pkg::ADDR_W-1:0]  branch_address,
	input  logic [bce_pkg::FREE_W-1:0]  spare_contexts,
	input  logic                        was_taken,
	input  logic                        was_correct,
	output logic                        push_valid,
	input  logic                        push_ready,
	output bce_pkg::bce_item_t          push_item
);

	logic [bce_pkg::HIST_W-1:0] hist_q;
	logic [bce_pkg::ADDR_W-1:0] addr_sh;
	logic [bce_pkg::ADDR_W-1:0] hist_ext;
	logic [bce_pkg::TCNT_W-1:0] cnt;
	logic [bce_pkg::FREE_W-1:0] fc;
	logic [bce_pkg::FREE_W-1:0] last;
	logic                       xfer;

	// Hold off new items while the table is being cleared
	assign in_ready   = push_ready && !bstat.clearing;
	assign push_valid = in_valid && !bstat.clearing;
	assign xfer       = in_valid && in_ready;

	// Index: shifted address, optionally XORed with history
	assign addr_sh  = branch_address >> bce_pkg::ADDR_SHIFT;
	assign hist_ext = cfg.use_hist ? bce_pkg::ADDR_W'(hist_q) : '0;

	// Pick threshold slot from free contexts
	always_comb begin
		cnt  = (cfg.thr_count == '0) ? bce_pkg::TCNT_W'(1) : cfg.thr_count;
		if (cnt > bce_pkg::TCNT_W'(bce_pkg::NUM_THR)) begin
			cnt = bce_pkg::TCNT_W'(bce_pkg::NUM_THR);
		end
		fc   = spare_contexts - bce_pkg::FREE_W'(1);
		last = bce_pkg::FREE_W'(cnt - bce_pkg::TCNT_W'(1));
		push_item.op         = operation;
		push_item.idx        = bce_pkg::IDX_W'(addr_sh ^ hist_ext);
		push_item.correct    = was_correct;
		push_item.force_high = 1'b0;
		push_item.tidx       = '0;
		if (cfg.thr_sel) begin
			if (spare_contexts == '0) begin
				push_item.force_high = 1'b1;
			end else if (fc < last) begin
				push_item.tidx = bce_pkg::TIDX_W'(fc);
			end else begin
				push_item.tidx = bce_pkg::TIDX_W'(last);
			end
		end
	end

	// Shift outcome into history on an update transfer while history is in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (xfer && operation == bce_pkg::OP_UPDATE && cfg.use_hist) begin
			hist_q <= {hist_q[bce_pkg::HIST_W-2:0], was_taken};
		end
	end

endmodule

// File: sv/bce_queue.sv
// ----------------------------------------------------------------------------
// Branch confidence estimator queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module bce_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  bce_pkg::bce_item_t  push_item,
	output logic                pop_valid,
	input  logic                pop_ready,
	output bce_pkg::bce_item_t  pop_item
);

	bce_pkg::bce_item_t          slot_q [bce_pkg::QUEUE_DEPTH];
	logic [bce_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [bce_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [bce_pkg::QCNT_W-1:0]  count_q;
	logic                        push;
	logic                        pop;

	assign push_ready = count_q != bce_pkg::QCNT_W'(bce_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bce_pkg::QPTR_W'(bce_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + bce_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bce_pkg::QPTR_W'(bce_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + bce_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + bce_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - bce_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// File: sv/bce_back.sv
// ----------------------------------------------------------------------------
// Branch confidence estimator back
// Owns the confidence table: clears it after reset, reads the entry,
// scores or trains it, writes it back and registers the result.
// ----------------------------------------------------------------------------
module bce_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bce_pkg::bce_cfg_t             cfg,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  bce_pkg::bce_item_t            q_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_high,
	output logic [bce_pkg::ENTRY_W-1:0]   out_data,
	output logic [bce_pkg::ENTRY_W-1:0]   out_entry,
	output bce_pkg::bce_bstat_t           bstat
);

	bce_pkg::bce_bstate_t          state_q, state_d;
	logic [bce_pkg::IDX_W-1:0]     clr_q, clr_d;
	logic [bce_pkg::ENTRY_W-1:0]   mem [bce_pkg::TABLE_ENTRIES];
	bce_pkg::bce_item_t            item_s1;
	logic [bce_pkg::ENTRY_W-1:0]   rdata_s1;
	logic                          out_valid_q;
	logic                          out_high_q;
	logic [bce_pkg::ENTRY_W-1:0]   out_data_q;
	logic [bce_pkg::ENTRY_W-1:0]   out_entry_q;

	logic                          pop;
	logic                          re;
	logic                          we;
	logic [bce_pkg::IDX_W-1:0]     ra;
	logic [bce_pkg::IDX_W-1:0]     wa;
	logic [bce_pkg::ENTRY_W-1:0]   wd;
	logic                          load_out;
	logic                          out_free;

	logic [bce_pkg::EBITS_W-1:0]   n_w;
	logic [bce_pkg::ENTRY_W-1:0]   mask;
	logic [bce_pkg::ENTRY_W-1:0]   half;
	logic [bce_pkg::ENTRY_W-1:0]   bits;
	logic [bce_pkg::MODE_W-1:0]    mode;
	logic                          sign;
	logic signed [bce_pkg::VAL_W-1:0] val;
	logic signed [bce_pkg::VAL_W-1:0] thr_v;
	logic [bce_pkg::THR_W-1:0]     thr_raw;
	logic [bce_pkg::ENTRY_W-1:0]   data;
	logic                          high;
	logic [bce_pkg::ENTRY_W-1:0]   new_bits;

	assign out_free = !out_valid_q || out_ready;

	// Width, mask and sign position of the current entry format
	always_comb begin
		if (cfg.entry_bits == '0) begin
			n_w = bce_pkg::EBITS_W'(1);
		end else if (cfg.entry_bits > bce_pkg::EBITS_W'(bce_pkg::ENTRY_W)) begin
			n_w = bce_pkg::EBITS_W'(bce_pkg::ENTRY_W);
		end else begin
			n_w = cfg.entry_bits;
		end
		mask = {bce_pkg::ENTRY_W{1'b1}} >> (bce_pkg::EBITS_W'(bce_pkg::ENTRY_W) - n_w);
		half = bce_pkg::ENTRY_W'(1) << (n_w - bce_pkg::EBITS_W'(1));
		mode = (cfg.entry_mode == bce_pkg::MODE_RESET_ALT) ? bce_pkg::MODE_RESET :
			cfg.entry_mode;
	end

	// Score the entry read for a lookup
	always_comb begin
		bits    = rdata_s1 & mask;
		sign    = |(bits & half);
		thr_raw = cfg.thr[item_s1.tidx];
		thr_v   = {thr_raw[bce_pkg::THR_W-1], thr_raw};
		case (mode)
			bce_pkg::MODE_ONES: begin
				val  = bce_pkg::VAL_W'(bce_pkg::popcount(bits));
				data = bits;
			end
			bce_pkg::MODE_SAT: begin
				val  = {2'b00, bits} - (sign ? {1'b0, half, 1'b0} : '0);
				data = bits ^ half;
			end
			default: begin
				val  = {2'b00, bits};
				data = bits;
			end
		endcase
		high = item_s1.force_high || (val >= thr_v);
	end

	// Train the entry for an update
	always_comb begin
		case (mode)
			bce_pkg::MODE_ONES: begin
				new_bits = ((bits << 1) | bce_pkg::ENTRY_W'(item_s1.correct)) & mask;
			end
			bce_pkg::MODE_SAT: begin
				if (item_s1.correct) begin
					new_bits = (bits == (mask >> 1)) ? bits :
						((bits + bce_pkg::ENTRY_W'(1)) & mask);
				end else begin
					new_bits = (bits == half) ? bits :
						((bits - bce_pkg::ENTRY_W'(1)) & mask);
				end
			end
			default: begin
				if (!item_s1.correct) begin
					new_bits = '0;
				end else if (bits < mask) begin
					new_bits = bits + bce_pkg::ENTRY_W'(1);
				end else begin
					new_bits = bits;
				end
			end
		endcase
	end

	// Sequencer: clear pass, then read one item and finish it in the exec state once the result register is free
	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		pop      = 1'b0;
		re       = 1'b0;
		ra       = q_item.idx;
		we       = 1'b0;
		wa       = clr_q;
		wd       = '0;
		load_out = 1'b0;
		case (state_q)
			bce_pkg::BS_CLEAR: begin
				we    = 1'b1;
				clr_d = clr_q + bce_pkg::IDX_W'(1);
				if (clr_q == {bce_pkg::IDX_W{1'b1}}) begin
					state_d = bce_pkg::BS_IDLE;
				end
			end
			bce_pkg::BS_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					re      = 1'b1;
					state_d = bce_pkg::BS_EXEC;
				end
			end
			bce_pkg::BS_EXEC: begin
				if (out_free) begin
					load_out = 1'b1;
					if (item_s1.op == bce_pkg::OP_UPDATE) begin
						we = 1'b1;
						wa = item_s1.idx;
						wd = new_bits;
					end
					if (q_valid) begin
						pop = 1'b1;
						re  = 1'b1;
					end else begin
						state_d = bce_pkg::BS_IDLE;
					end
				end
			end
			default: begin
				state_d = bce_pkg::BS_IDLE;
			end
		endcase
	end

	// State and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bce_pkg::BS_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
		end
	end

	// Table write and registered read, forwarding a same-cycle write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_s1 <= (we && wa == ra) ? wd : mem[ra];
		end
	end

	// Capture the popped item
	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= q_item;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (item_s1.op == bce_pkg::OP_UPDATE) begin
				out_high_q  <= 1'b0;
				out_data_q  <= '0;
				out_entry_q <= new_bits;
			end else begin
				out_high_q  <= high;
				out_data_q  <= data;
				out_entry_q <= bits;
			end
		end
	end

	assign q_ready         = pop;
	assign out_valid       = out_valid_q;
	assign out_high        = out_high_q;
	assign out_data        = out_data_q;
	assign out_entry       = out_entry_q;
	assign bstat.clearing  = state_q == bce_pkg::BS_CLEAR;
	assign bstat.executing = state_q == bce_pkg::BS_EXEC;

endmodule

// File: sv/branch_confidence_estimator_top.sv
// ----------------------------------------------------------------------------
// Branch confidence estimator
// Path: an input transfer goes through the queue, the table read and the result register.
// Throughput: one item per cycle while the result channel is not stalled; the back reads the
// table and writes the trained entry back in the exec state, forwarding it to a read of the same entry.
// Reset: a pass clears all 1024 table entries; in_ready is low until it ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module branch_confidence_estimator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bce_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bce_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [bce_pkg::ADDR_W-1:0]        branch_address,
	input  logic [bce_pkg::FREE_W-1:0]        spare_contexts,
	input  logic                              was_taken,
	input  logic                              was_correct,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              high_confidence,
	output logic [bce_pkg::ENTRY_W-1:0]       confidence_data,
	output logic [bce_pkg::ENTRY_W-1:0]       entry_value
);

	bce_pkg::bce_cfg_t    cfg_q;
	bce_pkg::bce_bstat_t  bstat;
	bce_pkg::bce_item_t   push_item;
	bce_pkg::bce_item_t   pop_item;
	logic                 push_valid;
	logic                 push_ready;
	logic                 pop_valid;
	logic                 pop_ready;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_mode <= bce_pkg::RST_ENTRY_MODE;
			cfg_q.entry_bits <= bce_pkg::RST_ENTRY_BITS;
			cfg_q.use_hist   <= 1'b0;
			cfg_q.thr_sel    <= 1'b0;
			cfg_q.thr_count  <= bce_pkg::RST_THR_COUNT;
			cfg_q.thr        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bce_pkg::REG_ENTRY_MODE: cfg_q.entry_mode <= cfg_data[bce_pkg::MODE_W-1:0];
				bce_pkg::REG_ENTRY_BITS: cfg_q.entry_bits <= cfg_data[bce_pkg::EBITS_W-1:0];
				bce_pkg::REG_USE_HIST:   cfg_q.use_hist   <= cfg_data[0];
				bce_pkg::REG_THR_SEL:    cfg_q.thr_sel    <= cfg_data[0];
				bce_pkg::REG_THR_COUNT:  cfg_q.thr_count  <= cfg_data[bce_pkg::TCNT_W-1:0];
				bce_pkg::REG_THR_ZERO:   cfg_q.thr[0]     <= cfg_data[bce_pkg::THR_W-1:0];
				bce_pkg::REG_THR_ONE:    cfg_q.thr[1]     <= cfg_data[bce_pkg::THR_W-1:0];
				bce_pkg::REG_THR_TWO:    cfg_q.thr[2]     <= cfg_data[bce_pkg::THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bce_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.bstat          (bstat),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.branch_address (branch_address),
		.spare_contexts (spare_contexts),
		.was_taken      (was_taken),
		.was_correct    (was_correct),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_item      (push_item)
	);

	bce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	bce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_item    (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_high  (high_confidence),
		.out_data  (confidence_data),
		.out_entry (entry_value),
		.bstat     (bstat)
	);

	// No input transfer during the clearing pass
	`ASSERT_IMPL(a_no_xfer_in_clear, in_valid && in_ready, !bstat.clearing)
	// Clearing pass runs once after reset
	`ASSERT_NEXT(a_clear_once, !bstat.clearing, !bstat.clearing)
	// A result only appears after the back finished an item
	`ASSERT_IMPL(a_out_from_exec, $rose(out_valid), $past(bstat.executing))

endmodule

// File: tb/tb_branch_confidence_estimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Branch confidence estimator testbench
// Drives lookups and updates through the valid/ready input channel and
// reprograms the registers between phases. A scoreboard keeps its own copy of
// the confidence table, the global history and the registers, predicts one
// verdict per accepted transfer and checks results in order. A short directed
// run covers field extremes and corner modes; random phases follow.
// ----------------------------------------------------------------------------

import bce_pkg::*;

// One result transfer as seen on the output channel
typedef struct packed {
	logic               high;
	logic [ENTRY_W-1:0] data;
	logic [ENTRY_W-1:0] entry;
} verdict_t;

// Bits in use per entry after clamping the register value
function automatic int eff_width(input logic [EBITS_W-1:0] eb);
	if (eb == '0)
		return 1;
	if (int'(eb) > ENTRY_W)
		return ENTRY_W;
	return int'(eb);
endfunction

class bce_scoreboard;
	logic [ENTRY_W-1:0] entries [TABLE_ENTRIES];
	logic [HIST_W-1:0]  history;
	logic [MODE_W-1:0]  entry_mode;
	logic [EBITS_W-1:0] entry_bits;
	logic               use_hist;
	logic               thr_sel;
	logic [TCNT_W-1:0]  thr_count;
	logic [THR_W-1:0]   thr [NUM_THR];
	verdict_t           expected_verdicts[$];
	int                 errors;

	function new();
		foreach (entries[i]) entries[i] = '0;
		foreach (thr[i]) thr[i] = '0;
		history    = '0;
		entry_mode = RST_ENTRY_MODE;
		entry_bits = RST_ENTRY_BITS;
		use_hist   = 1'b0;
		thr_sel    = 1'b0;
		thr_count  = RST_THR_COUNT;
		errors     = 0;
	endfunction

	function void write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		case (index)
			REG_ENTRY_MODE: entry_mode = data[MODE_W-1:0];
			REG_ENTRY_BITS: entry_bits = data[EBITS_W-1:0];
			REG_USE_HIST:   use_hist   = data[0];
			REG_THR_SEL:    thr_sel    = data[0];
			REG_THR_COUNT:  thr_count  = data[TCNT_W-1:0];
			REG_THR_ZERO:   thr[0]     = data[THR_W-1:0];
			REG_THR_ONE:    thr[1]     = data[THR_W-1:0];
			REG_THR_TWO:    thr[2]     = data[THR_W-1:0];
			default: ;
		endcase
	endfunction

	// Work out the verdict of one accepted transfer and train the table copy
	function void predict_item(input logic op, input logic [ADDR_W-1:0] addr,
			input logic [FREE_W-1:0] free_ctx, input logic taken, input logic correct);
		int                 n;
		int                 half;
		int                 sval;
		int                 val;
		int                 tidx;
		int                 cnt;
		logic [ENTRY_W-1:0] mask;
		logic [ENTRY_W-1:0] bits;
		logic [IDX_W-1:0]   idx;
		logic [MODE_W-1:0]  mode;
		verdict_t           v;
		n    = eff_width(entry_bits);
		mask = ENTRY_W'((17'd1 << n) - 17'd1);
		idx  = IDX_W'(addr >> ADDR_SHIFT) ^ (use_hist ? history : '0);
		bits = entries[idx] & mask;
		mode = (entry_mode == MODE_RESET_ALT) ? MODE_RESET : entry_mode;
		half = 1 << (n - 1);
		sval = int'(bits);
		if (bits[n-1])
			sval = sval - 2 * half;
		v = '0;
		if (op == OP_LOOKUP) begin
			case (mode)
				MODE_ONES: begin
					val    = $countones(bits);
					v.data = bits;
				end
				MODE_SAT: begin
					val    = sval;
					v.data = ENTRY_W'(sval + half);
				end
				default: begin
					val    = int'(bits);
					v.data = bits;
				end
			endcase
			// Pick the threshold; no free context means a negative index
			if (!thr_sel) begin
				tidx = 0;
			end else begin
				cnt  = (thr_count == '0) ? 1 : int'(thr_count);
				tidx = int'(free_ctx) - 1;
				if (tidx > cnt - 1)
					tidx = cnt - 1;
			end
			if (tidx < 0)
				v.high = 1'b1;
			else
				v.high = (val >= int'($signed(thr[tidx])));
			v.entry = bits;
		end else begin
			case (mode)
				MODE_ONES: bits = ((bits << 1) | ENTRY_W'(correct)) & mask;
				MODE_SAT: begin
					if (correct) begin
						if (sval < half - 1)
							sval++;
					end else if (sval > -half) begin
						sval--;
					end
					bits = ENTRY_W'(sval) & mask;
				end
				default: begin
					if (!correct)
						bits = '0;
					else if (bits < mask)
						bits = bits + 1'b1;
				end
			endcase
			entries[idx] = bits;
			if (use_hist)
				history = {history[HIST_W-2:0], taken};
			v.entry = bits;
		end
		expected_verdicts.push_back(v);
	endfunction

	// Compare one result transfer with the oldest expected verdict
	function void check_verdict(input logic high, input logic [ENTRY_W-1:0] data,
			input logic [ENTRY_W-1:0] entry);
		verdict_t v;
		if (expected_verdicts.size() == 0) begin
			$error("result transfer with no verdict expected");
			errors++;
			return;
		end
		v = expected_verdicts.pop_front();
		if (high !== v.high) begin
			$error("high_confidence: expected %0d, got %0d", v.high, high);
			errors++;
		end
		if (data !== v.data) begin
			$error("confidence_data: expected 0x%04h, got 0x%04h", v.data, data);
			errors++;
		end
		if (entry !== v.entry) begin
			$error("entry_value: expected 0x%04h, got 0x%04h", v.entry, entry);
			errors++;
		end
	endfunction

	function int pending();
		return expected_verdicts.size();
	endfunction
endclass

module tb_branch_confidence_estimator_top;

	localparam int STALL_LIMIT  = 4000;
	localparam int PHASE_ITEMS  = 128;
	localparam int RAND_PHASES  = 10;
	localparam int IDLE_PCT     = 33;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  operation = OP_LOOKUP;
	logic [ADDR_W-1:0]     branch_address = '0;
	logic [FREE_W-1:0]     spare_contexts = '0;
	logic                  was_taken = 1'b0;
	logic                  was_correct = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  high_confidence;
	logic [ENTRY_W-1:0]    confidence_data;
	logic [ENTRY_W-1:0]    entry_value;

	bce_scoreboard sb;
	bit            calm = 1'b0;
	int            stall_cycles = 0;
	int            phase;
	int            width_sel;

	branch_confidence_estimator_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.branch_address  (branch_address),
		.spare_contexts  (spare_contexts),
		.was_taken       (was_taken),
		.was_correct     (was_correct),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.high_confidence (high_confidence),
		.confidence_data (confidence_data),
		.entry_value     (entry_value)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Roll for an idle cycle, never during the calm stretch
	function automatic bit idle_roll();
		return !calm && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	// Stall the result channel at random
	always @(posedge clk) begin
		out_ready <= !idle_roll();
	end

	// Feed the scoreboard from every transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.predict_item(operation, branch_address, spare_contexts, was_taken,
					was_correct);
			if (out_valid && out_ready)
				sb.check_verdict(high_confidence, confidence_data, entry_value);
		end
	end

	// Abort when no transfer has happened for too long
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_branch_confidence_estimator_top: errors");
			$finish;
		end
	end

	// Present one register write and hold it until the transfer
	task automatic put_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic apply_settings(input logic [MODE_W-1:0] mode,
			input logic [EBITS_W-1:0] ebits, input logic hist, input logic sel,
			input logic [TCNT_W-1:0] cnt, input logic [THR_W-1:0] t0,
			input logic [THR_W-1:0] t1, input logic [THR_W-1:0] t2);
		put_reg(REG_ENTRY_MODE, CFG_DATA_W'(mode));
		put_reg(REG_ENTRY_BITS, CFG_DATA_W'(ebits));
		put_reg(REG_USE_HIST, CFG_DATA_W'(hist));
		put_reg(REG_THR_SEL, CFG_DATA_W'(sel));
		put_reg(REG_THR_COUNT, CFG_DATA_W'(cnt));
		put_reg(REG_THR_ZERO, t0);
		put_reg(REG_THR_ONE, t1);
		put_reg(REG_THR_TWO, t2);
		cfg_valid <= 1'b0;
	endtask

	// Send one item after random idle cycles with valid low; valid stays high until the item is taken
	task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
			input logic [FREE_W-1:0] free_ctx, input logic taken, input logic correct);
		while (idle_roll()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= op;
		branch_address <= addr;
		spare_contexts <= free_ctx;
		was_taken      <= taken;
		was_correct    <= correct;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every verdict has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Threshold near the reachable values of an n-bit entry, or an extreme
	function automatic logic [THR_W-1:0] rand_thr(input logic [EBITS_W-1:0] ebits);
		int n;
		int lo;
		int hi;
		int v;
		n = eff_width(ebits);
		case ($urandom_range(0, 7))
			0: return 17'h18000;
			1: return 17'h0FFFF;
			default: begin
				lo = -(1 << (n - 1)) - 1;
				hi = (1 << n) + 1;
				if (lo < -32768)
					lo = -32768;
				if (hi > 65535)
					hi = 65535;
				v = lo + int'($urandom_range(0, hi - lo));
				return v[THR_W-1:0];
			end
		endcase
	endfunction

	// Random items over a small pool of entries so that counters saturate
	task automatic run_phase(input int count, input int upd_pct, input int ok_pct,
			input int taken_pct);
		int                slot;
		logic [ADDR_W-1:0] addr;
		logic              op;
		for (int k = 0; k < count; k++) begin
			slot = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, TABLE_ENTRIES - 1))
				: int'($urandom_range(0, 7));
			addr = ($urandom & ~(32'(TABLE_ENTRIES - 1) << ADDR_SHIFT))
				| (32'(slot) << ADDR_SHIFT);
			op = ($urandom_range(0, 99) < upd_pct) ? OP_UPDATE : OP_LOOKUP;
			send_item(op, addr, FREE_W'($urandom_range(0, 15)),
				$urandom_range(0, 99) < taken_pct, $urandom_range(0, 99) < ok_pct);
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Saturating 2-bit counter, selector on, three thresholds
		apply_settings(MODE_SAT, 5'd2, 1'b0, 1'b1, 2'd3, 17'd0, 17'd1, 17'h1FFFF);
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, 4'd0, 1'b0, 1'b0);
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1);
		repeat (3) send_item(OP_UPDATE, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1);
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, 4'd1, 1'b0, 1'b0);
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, 4'd2, 1'b0, 1'b0);
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, 4'd3, 1'b0, 1'b0);
		repeat (4) send_item(OP_UPDATE, 32'hFFFF_FFFF, 4'd0, 1'b0, 1'b0);
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, 4'd15, 1'b0, 1'b0);
		send_item(OP_UPDATE, 32'h0000_0000, 4'd0, 1'b0, 1'b1);
		drain();

		// Alternate reset mode, zero width, history on, zero threshold count
		apply_settings(MODE_RESET_ALT, 5'd0, 1'b1, 1'b0, 2'd0, 17'h18000, 17'h0FFFF,
			17'd0);
		send_item(OP_UPDATE, 32'h0000_0000, 4'd0, 1'b1, 1'b1);
		send_item(OP_UPDATE, 32'h0000_0000, 4'd0, 1'b0, 1'b1);
		send_item(OP_LOOKUP, 32'h0000_0000, 4'd0, 1'b0, 1'b0);
		send_item(OP_LOOKUP, 32'h0000_0008, 4'd5, 1'b0, 1'b0);
		send_item(OP_UPDATE, 32'h0000_0008, 4'd0, 1'b1, 1'b0);
		send_item(OP_LOOKUP, 32'h0000_0008, 4'd15, 1'b0, 1'b0);
		drain();

		// Ones mode over wide entries left from the counter modes
		apply_settings(MODE_ONES, 5'd31, 1'b0, 1'b1, 2'd0, 17'h0FFFF, 17'd0, 17'd0);
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, 4'd1, 1'b0, 1'b0);
		send_item(OP_UPDATE, 32'hFFFF_FFFF, 4'd1, 1'b0, 1'b1);
		send_item(OP_UPDATE, 32'hFFFF_FFFF, 4'd1, 1'b1, 1'b0);
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, 4'd2, 1'b0, 1'b0);
		send_item(OP_LOOKUP, 32'h0000_0000, 4'd0, 1'b0, 1'b0);
		drain();

		// Random phases, each under its own settings
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				1: width_sel = 1;
				2: width_sel = 16;
				4: width_sel = 31;
				6: width_sel = 0;
				default: width_sel = int'($urandom_range(2, 6));
			endcase
			apply_settings(MODE_W'(phase % 4), EBITS_W'(width_sel),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				TCNT_W'($urandom_range(0, 3)), rand_thr(EBITS_W'(width_sel)),
				rand_thr(EBITS_W'(width_sel)), rand_thr(EBITS_W'(width_sel)));
			calm = (phase == 5);
			run_phase(PHASE_ITEMS, int'($urandom_range(30, 70)),
				int'($urandom_range(20, 90)), (phase % 3 == 0) ? 95 : (phase % 3 == 1) ? 5 : 50);
			drain();
			calm = 1'b0;
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_branch_confidence_estimator_top: clean");
		else
			$display("tb_branch_confidence_estimator_top: errors");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/bce_pkg.sv
sv/bce_front.sv
sv/bce_queue.sv
sv/bce_back.sv
sv/branch_confidence_estimator_top.sv
tb/tb_branch_confidence_estimator_top.sv
